>>> rtl/psp_pkg.sv
// Package: shared types, constants and helpers for the process selection policy block.
`default_nettype none
package psp_pkg;

    localparam int NUM_PROCS   = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int IDX_W       = $clog2(NUM_PROCS);
    localparam int PROD_W      = 2 * COUNT_WIDTH;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [1:0] {
        POL_FCFS = 2'd0,
        POL_RR   = 2'd1,
        POL_SPN  = 2'd2,
        POL_HRRN = 2'd3
    } policy_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        op;
        logic [3:0]  entry_index;
        logic [15:0] remaining;
        logic [15:0] waited;
        logic        current_valid;
        logic [3:0]  current_index;
    } in_t;

    typedef struct packed {
        logic       found;
        logic [3:0] chosen_index;
    } out_t;

    typedef struct packed {
        count_t rem;
        count_t wai;
    } entry_t;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic clr;
        logic ev;
        idx_t idx;
    } ctrl_t;

    function automatic logic in_range(input logic [3:0] i);
        return 32'(i) < NUM_PROCS;
    endfunction

    function automatic idx_t next_idx(input idx_t i);
        return (i == IDX_W'(NUM_PROCS - 1)) ? '0 : i + IDX_W'(1);
    endfunction

endpackage
`default_nettype wire

>>> rtl/psp_table.sv
// Process table: one write port, one registered read port, per-entry valid bits.
`default_nettype none
module psp_table (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            we,
    input  psp_pkg::idx_t        waddr,
    input  psp_pkg::entry_t      wdata,
    input  psp_pkg::idx_t        raddr,
    output psp_pkg::entry_t      rdata
);

    psp_pkg::entry_t                mem [psp_pkg::NUM_PROCS];
    logic [psp_pkg::NUM_PROCS-1:0]  valid_reg;
    psp_pkg::entry_t                rd_q_reg;
    logic                           rd_ok_reg;

    always_ff @(posedge clk) begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_q_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_ok_reg <= valid_reg[raddr];
        end
    end

    // never-written entries read as the cleared value
    assign rdata = rd_ok_reg ? rd_q_reg : '0;

endmodule
`default_nettype wire

>>> rtl/psp_ctrl.sv
// Sequencer: walks the table one entry per cycle in the order the policy needs.
`default_nettype none
module psp_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          sel_go,
    input  psp_pkg::policy_t   policy,
    input  wire logic          cur_valid,
    input  wire logic [3:0]    cur_index,
    output psp_pkg::idx_t      raddr,
    output psp_pkg::ctrl_t     ctl,
    output logic               busy,
    output logic               done
);

    psp_pkg::state_t state_reg, state_next;
    psp_pkg::idx_t   addr_reg, addr_next;
    psp_pkg::idx_t   cnt_reg, cnt_next;
    logic            pre_reg, pre_next;
    logic            ev_reg, ev_next;
    psp_pkg::idx_t   ev_idx_reg, ev_idx_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg  <= psp_pkg::ST_IDLE;
            addr_reg   <= '0;
            cnt_reg    <= '0;
            pre_reg    <= 1'b0;
            ev_reg     <= 1'b0;
            ev_idx_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            cnt_reg    <= cnt_next;
            pre_reg    <= pre_next;
            ev_reg     <= ev_next;
            ev_idx_reg <= ev_idx_next;
        end
    end

    always_comb begin
        logic          cv;
        psp_pkg::idx_t ci;
        cv          = cur_valid && psp_pkg::in_range(cur_index);
        ci          = psp_pkg::IDX_W'(cur_index);
        state_next  = state_reg;
        addr_next   = addr_reg;
        cnt_next    = cnt_reg;
        pre_next    = pre_reg;
        ev_next     = 1'b0;
        ev_idx_next = addr_reg;
        ctl.clr     = 1'b0;
        ctl.ev      = ev_reg;
        ctl.idx     = ev_idx_reg;
        done        = 1'b0;
        case (state_reg)
            psp_pkg::ST_IDLE:
            begin
                if (sel_go)
                begin
                    ctl.clr    = 1'b1;
                    cnt_next   = '0;
                    state_next = psp_pkg::ST_SCAN;
                    pre_next   = 1'b0;
                    addr_next  = '0;
                    // FCFS looks at the running entry first, RR starts just past it
                    if (cv && policy == psp_pkg::POL_FCFS)
                    begin
                        pre_next  = 1'b1;
                        addr_next = ci;
                    end
                    else if (cv && policy == psp_pkg::POL_RR)
                    begin
                        addr_next = psp_pkg::next_idx(ci);
                    end
                end
            end
            psp_pkg::ST_SCAN:
            begin
                ev_next = 1'b1;
                if (pre_reg)
                begin
                    pre_next  = 1'b0;
                    addr_next = '0;
                end
                else
                begin
                    addr_next = psp_pkg::next_idx(addr_reg);
                    cnt_next  = cnt_reg + psp_pkg::IDX_W'(1);
                    if (cnt_reg == psp_pkg::IDX_W'(psp_pkg::NUM_PROCS - 1))
                    begin
                        state_next = psp_pkg::ST_DRAIN;
                    end
                end
            end
            psp_pkg::ST_DRAIN:
            begin
                state_next = psp_pkg::ST_DONE;
            end
            psp_pkg::ST_DONE:
            begin
                done       = 1'b1;
                state_next = psp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = psp_pkg::ST_IDLE;
            end
        endcase
    end

    assign raddr   = addr_reg;
    assign busy    = (state_reg != psp_pkg::ST_IDLE);

endmodule
`default_nettype wire

>>> rtl/psp_unit.sv
// Compare unit: weighs each scanned entry against the best one held so far.
`default_nettype none
module psp_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  psp_pkg::policy_t   policy,
    input  psp_pkg::ctrl_t     ctl,
    input  psp_pkg::entry_t    rd,
    output psp_pkg::out_t      res
);

    logic                          found_reg;
    psp_pkg::idx_t                 best_idx_reg;
    psp_pkg::count_t               best_rem_reg;
    psp_pkg::count_t               best_wai_reg;
    logic [psp_pkg::PROD_W-1:0]    lhs, rhs;
    logic                          better;
    logic                          take;

    // HRRN: w_i/r_i > w_b/r_b  <=>  w_i*r_b > w_b*r_i
    assign lhs = psp_pkg::PROD_W'(rd.wai) * psp_pkg::PROD_W'(best_rem_reg);
    assign rhs = psp_pkg::PROD_W'(best_wai_reg) * psp_pkg::PROD_W'(rd.rem);

    always_comb begin
        case (policy)
            psp_pkg::POL_SPN:  better = rd.rem < best_rem_reg;
            psp_pkg::POL_HRRN: better = lhs > rhs;
            default:           better = 1'b0;
        endcase
        take = ctl.ev && (rd.rem != '0) && (!found_reg || better);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            found_reg    <= 1'b0;
            best_idx_reg <= '0;
        end
        else if (ctl.clr)
        begin
            found_reg    <= 1'b0;
            best_idx_reg <= '0;
        end
        else if (take)
        begin
            found_reg    <= 1'b1;
            best_idx_reg <= ctl.idx;
        end
    end

    always_ff @(posedge clk) begin
        if (take)
        begin
            best_rem_reg <= rd.rem;
            best_wai_reg <= rd.wai;
        end
    end

    assign res.found        = found_reg;
    assign res.chosen_index = 4'(best_idx_reg);

endmodule
`default_nettype wire

>>> rtl/process_selection_policy.sv
// Select: after start is taken the block scans every entry, drains, then strobes done; FCFS
// with a running process scans that entry first; start is taken again the cycle after done.
// Write: busy stays low; one beat per cycle while no select is in flight.
// The single table read port sets the rate: one entry is compared per cycle.
// Reset clears the table (per-entry valid bits) and sets the policy to FCFS.
// Results come as a one-cycle done strobe; the receiver cannot stall.
`default_nettype none
module process_selection_policy (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  psp_pkg::in_t       item,
    output logic               busy,
    output logic               done,
    output psp_pkg::out_t      result,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_wdata
);

    psp_pkg::policy_t policy_reg;
    logic             accept;
    logic             tbl_we;
    psp_pkg::entry_t  wdata;
    psp_pkg::entry_t  rdata;
    psp_pkg::idx_t    raddr;
    psp_pkg::ctrl_t   ctl;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            policy_reg <= psp_pkg::POL_FCFS;
        end
        else if (cfg_we)
        begin
            policy_reg <= psp_pkg::policy_t'(cfg_wdata);
        end
    end

    assign accept    = start && !busy;
    assign tbl_we    = accept && item.op == psp_pkg::OP_WRITE
                       && psp_pkg::in_range(item.entry_index);
    assign wdata.rem = psp_pkg::COUNT_WIDTH'(item.remaining);
    assign wdata.wai = psp_pkg::COUNT_WIDTH'(item.waited);

    psp_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (tbl_we),
        .waddr (psp_pkg::IDX_W'(item.entry_index)),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    psp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .sel_go    (accept && item.op == psp_pkg::OP_SELECT),
        .policy    (policy_reg),
        .cur_valid (item.current_valid),
        .cur_index (item.current_index),
        .raddr     (raddr),
        .ctl       (ctl),
        .busy      (busy),
        .done      (done)
    );

    psp_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .policy (policy_reg),
        .ctl    (ctl),
        .rd     (rdata),
        .res    (result)
    );

endmodule
`default_nettype wire

>>> rtl/psp_checker.sv
// Port-level checks for the process selection policy block, bound to the top level.
`default_nettype none
module psp_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input psp_pkg::in_t       item,
    input wire logic          busy,
    input wire logic          done,
    input psp_pkg::out_t      result
);

    // a result beat only closes a select in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("still busy after result beat");

    a_sel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.op == psp_pkg::OP_SELECT) |=> (busy && !done))
        else $error("select not started");

    a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.op == psp_pkg::OP_WRITE) |=> (!busy && !done))
        else $error("write made the block busy");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.chosen_index == 4'd0))
        else $error("nonzero index with no process found");

endmodule

bind process_selection_policy psp_checker u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
);
`default_nettype wire
